// File: rtl/core/cr2u_pkg.sv
package cr2u_pkg;

	// Unicode limits
	localparam logic [20:0] MAX_CODE = 21'h10ffff;
	localparam logic [20:0] SURR_LO  = 21'h00d800;
	localparam logic [20:0] SURR_HI  = 21'h00dfff;

	// UTF-8 lead and continuation marks
	localparam logic [7:0] LEAD2     = 8'hc0;
	localparam logic [7:0] LEAD3     = 8'he0;
	localparam logic [7:0] LEAD4     = 8'hf0;
	localparam logic [7:0] CONT      = 8'h80;
	localparam logic [7:0] CONT_MASK = 8'h3f;

	// Case fold bit
	localparam logic [7:0] FOLD = 8'h20;

	// Parse phase of a reference body
	typedef enum logic [1:0] {
		PH_START,
		PH_HASH,
		PH_DIGITS,
		PH_NAME
	} phase_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       byte_present;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       decoded;
		logic       run_end;
	} out_item_t;

	// One encoded reference: up to four bytes, index of the final one, success
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            ok;
	} run_t;

	// Named references, lower case, padded with zero
	localparam int ENT_COUNT   = 10;
	localparam int ENT_MAX_LEN = 6;

	localparam logic [7:0] ENT_TEXT [ENT_COUNT][ENT_MAX_LEN] = '{
		'{"a", "m", "p", 8'h00, 8'h00, 8'h00},
		'{"l", "t", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"g", "t", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"q", "u", "o", "t", 8'h00, 8'h00},
		'{"a", "p", "o", "s", 8'h00, 8'h00},
		'{"n", "b", "s", "p", 8'h00, 8'h00},
		'{"n", "d", "a", "s", "h", 8'h00},
		'{"m", "d", "a", "s", "h", 8'h00},
		'{"h", "e", "l", "l", "i", "p"},
		'{"m", "i", "d", "d", "o", "t"}
	};

	localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{
		3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6
	};

	// nbsp decodes to a plain space
	localparam logic [20:0] ENT_CODE [ENT_COUNT] = '{
		21'h000026, 21'h00003c, 21'h00003e, 21'h000022, 21'h000027,
		21'h000020, 21'h002013, 21'h002014, 21'h002026, 21'h0000b7
	};

endpackage

// File: rtl/core/cr2u_stream_if.sv
interface cr2u_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/cr2u_utf8_enc.sv
module cr2u_utf8_enc (
	input  logic [20:0]     code_point,
	input  logic            code_ok,
	output cr2u_pkg::run_t  run
);

	logic surrogate;

	assign surrogate = (code_point >= cr2u_pkg::SURR_LO) && (code_point <= cr2u_pkg::SURR_HI);

	// Pick the encoding length and build the bytes; a failure is one zero byte
	always_comb begin
		run = '0;
		if (!code_ok || surrogate) begin
			run.ok = 1'b0;
		end else if (code_point <= 21'h00007f) begin
			run.bytes[0] = code_point[7:0];
			run.last_idx = 2'd0;
			run.ok       = 1'b1;
		end else if (code_point <= 21'h0007ff) begin
			run.bytes[0] = cr2u_pkg::LEAD2 | {3'b000, code_point[10:6]};
			run.bytes[1] = cr2u_pkg::CONT | ({2'b00, code_point[5:0]} & cr2u_pkg::CONT_MASK);
			run.last_idx = 2'd1;
			run.ok       = 1'b1;
		end else if (code_point <= 21'h00ffff) begin
			run.bytes[0] = cr2u_pkg::LEAD3 | {4'b0000, code_point[15:12]};
			run.bytes[1] = cr2u_pkg::CONT | ({2'b00, code_point[11:6]} & cr2u_pkg::CONT_MASK);
			run.bytes[2] = cr2u_pkg::CONT | ({2'b00, code_point[5:0]} & cr2u_pkg::CONT_MASK);
			run.last_idx = 2'd2;
			run.ok       = 1'b1;
		end else begin
			run.bytes[0] = cr2u_pkg::LEAD4 | {5'b00000, code_point[20:18]};
			run.bytes[1] = cr2u_pkg::CONT | ({2'b00, code_point[17:12]} & cr2u_pkg::CONT_MASK);
			run.bytes[2] = cr2u_pkg::CONT | ({2'b00, code_point[11:6]} & cr2u_pkg::CONT_MASK);
			run.bytes[3] = cr2u_pkg::CONT | ({2'b00, code_point[5:0]} & cr2u_pkg::CONT_MASK);
			run.last_idx = 2'd3;
			run.ok       = 1'b1;
		end
	end

endmodule

// File: rtl/core/char_reference_to_utf8.sv
// Decodes the body of an HTML character reference (the bytes between '&' and ';'),
// one body byte per item, into its UTF-8 bytes. Numeric bodies (#nnn, #xhh, any
// number of digits, value up to 0x10FFFF, no surrogates) and ten case-insensitive
// names are understood; anything else gives a single result with decoded low.
// Items are taken every cycle while no last item waits in the input register.
// An item marked last is decoded in one pass and produces a run of one to four
// result items, one per cycle while the output is ready, from the output run
// register that it is loaded into. That register holds one reference, so a last
// item waits in the input register, and holds off the items behind it, until the
// final byte of the previous run is taken.
module char_reference_to_utf8 #(
	parameter int NAME_BYTES = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	cr2u_stream_if.sink     body,
	cr2u_stream_if.source   utf8
);

	localparam int CW = $clog2(NAME_BYTES + 2);
	localparam int IW = $clog2(NAME_BYTES);

	// Input register
	logic                 valid_s1;
	cr2u_pkg::in_item_t   item_s1;
	cr2u_pkg::in_item_t   item_in;

	// Parse state
	cr2u_pkg::phase_t     phase_q, phase_n;
	logic [CW-1:0]        count_q, count_n;
	logic [7:0]           store_q [NAME_BYTES];
	logic [7:0]           store_n [NAME_BYTES];
	logic [20:0]          code_q, code_n;
	logic                 hex_q, hex_n;
	logic                 seen_q, seen_n;
	logic                 rej_q, rej_n;

	// Digit datapath
	logic [7:0]           low;
	logic                 is_dec, is_hexl, digit_ok;
	logic [3:0]           digit;
	logic [24:0]          prod, sum;
	logic                 over;
	logic                 do_digit, do_name;

	// Name match and encoder
	logic                 ent_hit;
	logic [20:0]          ent_cp;
	logic [20:0]          code_point;
	logic                 code_ok;
	cr2u_pkg::run_t       enc_run;

	// Output run
	cr2u_pkg::run_t       run_q;
	logic                 pend_q;
	logic [1:0]           idx_q;
	cr2u_pkg::out_item_t  out_item;

	logic                 run_done, out_free, s1_adv, load;

	assign item_in = body.data;

	// Handshake control
	assign run_done   = pend_q && utf8.ready && (idx_q == run_q.last_idx);
	assign out_free   = !pend_q || run_done;
	assign s1_adv     = valid_s1 && (!item_s1.is_last || out_free);
	assign load       = s1_adv && item_s1.is_last;
	assign body.ready = !valid_s1 || s1_adv;

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.valid && body.ready) begin
			item_s1 <= item_in;
		end
	end

	// Classify the byte as a digit and form the accumulated value
	always_comb begin
		low      = item_s1.body_byte | cr2u_pkg::FOLD;
		is_dec   = (item_s1.body_byte >= "0") && (item_s1.body_byte <= "9");
		is_hexl  = (low >= "a") && (low <= "f");
		digit_ok = is_dec || (hex_q && is_hexl);
		digit    = is_dec ? item_s1.body_byte[3:0] : (low[3:0] + 4'd9);
		prod     = hex_q ? {code_q, 4'b0000}
		                 : ({1'b0, code_q, 3'b000} + {3'b000, code_q, 1'b0});
		sum      = prod + {21'b0, digit};
		over     = sum > {4'b0000, cr2u_pkg::MAX_CODE};
	end

	// Advance the parse state by one byte
	always_comb begin
		phase_n  = phase_q;
		count_n  = count_q;
		store_n  = store_q;
		code_n   = code_q;
		hex_n    = hex_q;
		seen_n   = seen_q;
		rej_n    = rej_q;
		do_digit = 1'b0;
		do_name  = 1'b0;

		if (item_s1.byte_present) begin
			case (phase_q)
				cr2u_pkg::PH_START: begin
					if (item_s1.body_byte == "#") begin
						phase_n = cr2u_pkg::PH_HASH;
					end else begin
						phase_n = cr2u_pkg::PH_NAME;
						do_name = 1'b1;
					end
				end
				cr2u_pkg::PH_HASH: begin
					phase_n = cr2u_pkg::PH_DIGITS;
					if (item_s1.body_byte == "x" || item_s1.body_byte == "X") begin
						hex_n = 1'b1;
					end else begin
						do_digit = 1'b1;
					end
				end
				cr2u_pkg::PH_DIGITS: begin
					do_digit = 1'b1;
				end
				default: begin
					do_name = 1'b1;
				end
			endcase
		end

		// Accumulate a digit; a bad digit or overflow rejects the body
		if (do_digit && !rej_q) begin
			if (!digit_ok || over) begin
				rej_n = 1'b1;
			end else begin
				code_n = sum[20:0];
				seen_n = 1'b1;
			end
		end

		// Store a folded name byte; a long name saturates the count
		if (do_name) begin
			if (count_q < CW'(NAME_BYTES)) begin
				store_n[count_q[IW-1:0]] = low;
				count_n = count_q + CW'(1);
			end else begin
				count_n = CW'(NAME_BYTES + 1);
			end
		end
	end

	// Match the name against the table, first entry wins
	always_comb begin
		logic same;
		same    = 1'b0;
		ent_hit = 1'b0;
		ent_cp  = '0;
		for (int k = cr2u_pkg::ENT_COUNT - 1; k >= 0; k--) begin
			same = (count_n == CW'(cr2u_pkg::ENT_LEN[k]));
			for (int i = 0; i < cr2u_pkg::ENT_MAX_LEN; i++) begin
				if ((i < int'(cr2u_pkg::ENT_LEN[k])) &&
				    (store_n[i] != cr2u_pkg::ENT_TEXT[k][i])) begin
					same = 1'b0;
				end
			end
			if (same) begin
				ent_hit = 1'b1;
				ent_cp  = cr2u_pkg::ENT_CODE[k];
			end
		end
	end

	// Select the code point of the finished body
	always_comb begin
		code_point = (phase_n == cr2u_pkg::PH_NAME) ? ent_cp : code_n;
		code_ok    = ((phase_n == cr2u_pkg::PH_DIGITS) && !rej_n && seen_n) ||
		             ((phase_n == cr2u_pkg::PH_NAME) && ent_hit);
	end

	cr2u_utf8_enc u_enc (
		.code_point (code_point),
		.code_ok    (code_ok),
		.run        (enc_run)
	);

	// Update parse state; clear it after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cr2u_pkg::PH_START;
			count_q <= '0;
			code_q  <= '0;
			hex_q   <= 1'b0;
			seen_q  <= 1'b0;
			rej_q   <= 1'b0;
		end else if (s1_adv) begin
			if (item_s1.is_last) begin
				phase_q <= cr2u_pkg::PH_START;
				count_q <= '0;
				code_q  <= '0;
				hex_q   <= 1'b0;
				seen_q  <= 1'b0;
				rej_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				count_q <= count_n;
				code_q  <= code_n;
				hex_q   <= hex_n;
				seen_q  <= seen_n;
				rej_q   <= rej_n;
			end
		end
	end

	// Name bytes hold no reset; only written entries are compared
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			store_q <= store_n;
		end
	end

	// Load a finished run and step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			pend_q <= 1'b1;
			idx_q  <= '0;
		end else if (pend_q && utf8.ready) begin
			if (idx_q == run_q.last_idx) begin
				pend_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= enc_run;
		end
	end

	// Drive the result item
	always_comb begin
		out_item.utf8_byte = run_q.bytes[idx_q];
		out_item.decoded   = run_q.ok;
		out_item.run_end   = (idx_q == run_q.last_idx);
	end

	assign utf8.valid = pend_q;
	assign utf8.data  = out_item;

	// A failed reference is a single result
	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		utf8.valid && !utf8.data.decoded |-> utf8.data.run_end)
		else $error("failure result without run_end");

	// The first byte of a multi-byte run is a lead byte
	a_lead_byte: assert property (@(posedge clk) disable iff (!arst_n)
		utf8.valid && utf8.data.decoded && (idx_q == 2'd0) && !utf8.data.run_end
		|-> utf8.data.utf8_byte[7:6] == 2'b11)
		else $error("multi-byte run does not open with a lead byte");

	// A taken final byte with nothing new loaded leaves the output empty
	a_run_drains: assert property (@(posedge clk) disable iff (!arst_n)
		utf8.valid && utf8.ready && utf8.data.run_end && !load |=> !utf8.valid)
		else $error("output still valid after run end");

	// The input stalls only behind a last item waiting on a busy run
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !body.ready |-> item_s1.is_last && pend_q)
		else $error("input stalled without a pending run");

endmodule
